/* design/sse_pkg.sv */
package sse_pkg;

   // Default sizing of the store
   localparam int CAPACITY_DEF = 1024;
   localparam int KEY_BITS_DEF = 16;

   // Fixed field widths of the channels
   localparam int OPCODE_BITS = 2;
   localparam int REQ_KEY_BITS = 16;
   localparam int OCC_BITS = 11;

   // Fan-in of each node of the match tree
   localparam int TREE_RADIX = 16;

   // Request opcodes
   localparam logic [OPCODE_BITS-1:0] OP_MEMBER = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_DELETE = 2'd2;

   // Strobes broadcast from the sequencer to every cell of the chain
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } sse_ctl_type;

   // Number of registered levels needed to reduce width bits at the given fan-in
   function automatic int tree_levels(input int width, input int radix);
      int span;
      int lv;
      span = 1;
      lv = 0;
      while (span < width) begin
         span = span * radix;
         lv++;
      end
      if (lv == 0) begin
         lv = 1;
      end
      return lv;
   endfunction

endpackage

/* design/sse_channels.sv */
interface sse_req_if;
   import sse_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [REQ_KEY_BITS-1:0] key;

   modport source (output valid, output opcode, output key, input ready);
   modport sink (input valid, input opcode, input key, output ready);
endinterface

interface sse_rsp_if;
   import sse_pkg::*;

   logic                valid;
   logic                ready;
   logic                success;
   logic                full_reject;
   logic [OCC_BITS-1:0] occupancy;

   modport source (output valid, output success, output full_reject, output occupancy,
                   input ready);
   modport sink (input valid, input success, input full_reject, input occupancy,
                 output ready);
endinterface

/* design/sse_cell.sv */
module sse_cell
   import sse_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int CNT_BITS = 11,
   parameter int CELL_INDEX = 0
) (
   input  logic                clock,
   input  sse_ctl_type         ctl,
   input  logic [KEY_BITS-1:0] probe_key,
   input  logic [CNT_BITS-1:0] fill,
   input  logic                left_lt,
   input  logic [KEY_BITS-1:0] left_key,
   input  logic [KEY_BITS-1:0] right_key,
   output logic [KEY_BITS-1:0] key_out,
   output logic                lt_out,
   output logic                eq_out
);

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                lt_ff, lt_in;
   logic                eq_ff, eq_in;
   logic                live;

   // A cell holds a key only while its place lies below the fill count
   assign live = fill > CNT_BITS'(CELL_INDEX);

   always_comb begin
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      key_in = key_ff;
      if (ctl.compare) begin
         lt_in = live && (key_ff < probe_key);
         eq_in = live && (key_ff == probe_key);
      end
      // Cells below the probe hold; the rest open a gap or close one
      if (ctl.insert && !lt_ff) begin
         key_in = left_lt ? probe_key : left_key;
      end else if (ctl.remove && !lt_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule

/* design/sse_or_tree.sv */
module sse_or_tree
   import sse_pkg::*;
#(
   parameter int WIDTH = CAPACITY_DEF,
   parameter int RADIX = TREE_RADIX
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] bits,
   output logic             any
);

   localparam int LEVELS = tree_levels(WIDTH, RADIX);
   localparam int SPAN = RADIX ** LEVELS;
   localparam int NODES = SPAN / RADIX;

   logic [SPAN-1:0]  leaf;
   logic [NODES-1:0] node_ff [LEVELS];

   assign leaf = SPAN'(bits);

   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar j = 0; j < NODES; j++) begin : g_node
         if (l == 0) begin : g_first
            always_ff @(posedge clock) begin
               node_ff[l][j] <= |leaf[j*RADIX +: RADIX];
            end
         end else if (j * RADIX + RADIX <= NODES) begin : g_inner
            always_ff @(posedge clock) begin
               node_ff[l][j] <= |node_ff[l-1][j*RADIX +: RADIX];
            end
         end else begin : g_pad
            always_ff @(posedge clock) begin
               node_ff[l][j] <= 1'b0;
            end
         end
      end
   end

   assign any = node_ff[LEVELS-1][0];

endmodule

/* design/sorted_set_engine_core.sv */
// Sorted set engine: keeps an ascending set of distinct keys, at most CAPACITY of them.
// Request channel (req_ch): opcode and key; member query, insert or delete.
// Response channel (rsp_ch): success, full_reject and the occupancy after the request.
// Every request yields exactly one response, in request order.
// The keys live in a chain of CAPACITY cells; each compares the broadcast key with its
// own and, on a change, takes its neighbor's key to open or close a gap.
// Whether the key is held is gathered by a registered OR tree with TREE_RADIX fan-in,
// LEVELS = ceil(log_TREE_RADIX(CAPACITY)) levels (3 at the default 1024 entries).
// Each request passes from S_IDLE through S_CMP, S_WAIT and S_APPLY; the response is
// registered at the commit. A new request is taken only back in S_IDLE, after the last
// one commits; the tree depth sets how long S_WAIT lasts.
// The next request is taken while a response still waits in the output register.
// If the receiver stalls, the finished request holds before the commit step until the
// output register frees, so nothing changes in the store meanwhile.
// Reset (synchronous, active high) empties the set and drops any pending response.
module sorted_set_engine_core
   import sse_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sse_req_if.sink    req_ch,
   sse_rsp_if.source  rsp_ch
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int LEVELS = tree_levels(CAPACITY, TREE_RADIX);
   localparam int WAIT_BITS = $clog2(LEVELS + 1);

   // One-hot sequencer states
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CMP   = 4'b0010,
      S_WAIT  = 4'b0100,
      S_APPLY = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [OPCODE_BITS-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [WAIT_BITS-1:0]   wait_ff, wait_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                success_ff, success_in;
   logic                reject_ff, reject_in;
   logic [OCC_BITS-1:0] occ_ff, occ_in;

   logic [KEY_BITS+REQ_KEY_BITS-1:0] key_wide;
   logic [OCC_BITS+CNT_BITS-1:0]     occ_wide;

   logic                req_take;
   logic                commit;
   logic                held;
   logic                full;
   logic                do_ins;
   logic                do_del;
   sse_ctl_type         ctl;

   logic [KEY_BITS-1:0] cell_key [CAPACITY];
   logic [CAPACITY-1:0] lt_vec;
   logic [CAPACITY-1:0] eq_vec;

   // Keep only the low KEY_BITS of the request key, zero-extend if wider
   assign key_wide = {{KEY_BITS{1'b0}}, req_ch.key};

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   // Commit only once the output register can take the response
   assign commit = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ch.ready);

   assign full   = (count_ff == CNT_BITS'(CAPACITY));
   assign do_ins = (op_ff == OP_INSERT) && !held && !full;
   assign do_del = (op_ff == OP_DELETE) && held;

   always_comb begin
      ctl.compare = (state_ff == S_CMP);
      ctl.insert  = commit && do_ins;
      ctl.remove  = commit && do_del;
   end

   // Cell chain: each cell talks to its left and right neighbor only
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                left_lt;
      logic [KEY_BITS-1:0] left_key;
      logic [KEY_BITS-1:0] right_key;

      if (i == 0) begin : g_head
         // The head has no smaller neighbor: it always marks a gap boundary
         assign left_lt  = 1'b1;
         assign left_key = key_ff;
      end else begin : g_body
         assign left_lt  = lt_vec[i-1];
         assign left_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_key = cell_key[i];
      end else begin : g_link
         assign right_key = cell_key[i+1];
      end

      sse_cell #(
         .KEY_BITS   (KEY_BITS),
         .CNT_BITS   (CNT_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .probe_key (key_ff),
         .fill      (count_ff),
         .left_lt   (left_lt),
         .left_key  (left_key),
         .right_key (right_key),
         .key_out   (cell_key[i]),
         .lt_out    (lt_vec[i]),
         .eq_out    (eq_vec[i])
      );
   end

   sse_or_tree #(
      .WIDTH (CAPACITY),
      .RADIX (TREE_RADIX)
   ) u_match_tree (
      .clock (clock),
      .bits  (eq_vec),
      .any   (held)
   );

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      wait_in  = wait_ff;
      count_in = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               op_in    = req_ch.opcode;
               key_in   = key_wide[KEY_BITS-1:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            wait_in  = '0;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            // Advance until the match tree has settled
            if (wait_ff == WAIT_BITS'(LEVELS - 1)) begin
               state_in = S_APPLY;
            end else begin
               wait_in = wait_ff + WAIT_BITS'(1);
            end
         end
         S_APPLY: begin
            if (commit) begin
               if (do_ins) begin
                  count_in = count_ff + CNT_BITS'(1);
               end else if (do_del) begin
                  count_in = count_ff - CNT_BITS'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign occ_wide = {{OCC_BITS{1'b0}}, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      success_in   = success_ff;
      reject_in    = reject_ff;
      occ_in       = occ_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
         success_in   = ((op_ff == OP_MEMBER) && held) || do_ins || do_del;
         reject_in    = (op_ff == OP_INSERT) && !held && full;
         occ_in       = occ_wide[OCC_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset needed
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      success_ff <= success_in;
      reject_ff  <= reject_in;
      occ_ff     <= occ_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.success     = success_ff;
   assign rsp_ch.full_reject = reject_ff;
   assign rsp_ch.occupancy   = occ_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(CAPACITY))
      else $error("fill count beyond capacity");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_APPLY))
      else $error("response raised outside the commit step");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(success_ff && reject_ff))
      else $error("success and full_reject both set");

   a_count_at_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> $past(state_ff == S_APPLY))
      else $error("fill count moved outside the commit step");

   a_take_starts_compare: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_CMP)
      else $error("accepted request did not start a compare");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import sse_pkg::*;

   localparam int STORE_DEPTH = CAPACITY_DEF;
   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
   // Quiet cycles tolerated: covers the long receiver hold-off with margin.
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER = 400;
   // Drain time after the last response: tree depth plus commit steps, with margin.
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic                success;
      logic                full_reject;
      logic [OCC_BITS-1:0] occupancy;
   } set_outcome_type;

   // Ordered key set mirror plus the queue of responses still owed by the block.
   class key_set_tracker;
      logic [REQ_KEY_BITS-1:0] held_keys[$];
      set_outcome_type         owed[$];
      int                      errors = 0;
      int                      responses_checked = 0;

      function int size();
         return held_keys.size();
      endfunction

      function logic [REQ_KEY_BITS-1:0] key_at(int idx);
         return held_keys[idx];
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // Apply one accepted request to the mirror and queue its response.
      function void apply_request(logic [OPCODE_BITS-1:0] op, logic [REQ_KEY_BITS-1:0] k);
         int              pos;
         bit              held;
         set_outcome_type outcome;
         pos = 0;
         while (pos < held_keys.size() && held_keys[pos] < k) begin
            pos++;
         end
         held = (pos < held_keys.size()) && (held_keys[pos] == k);
         outcome.success = 1'b0;
         outcome.full_reject = 1'b0;
         case (op)
            OP_MEMBER: begin
               outcome.success = held;
            end
            OP_INSERT: begin
               if (!held) begin
                  if (held_keys.size() >= STORE_DEPTH) begin
                     outcome.full_reject = 1'b1;
                  end else begin
                     held_keys.insert(pos, k);
                     outcome.success = 1'b1;
                  end
               end
            end
            OP_DELETE: begin
               if (held) begin
                  held_keys.delete(pos);
                  outcome.success = 1'b1;
               end
            end
            default: begin
            end
         endcase
         outcome.occupancy = OCC_BITS'(held_keys.size());
         owed.push_back(outcome);
      endfunction

      function void check_response(logic s, logic fr, logic [OCC_BITS-1:0] occ);
         set_outcome_type want;
         responses_checked++;
         if (owed.size() == 0) begin
            $error("response with no request outstanding: %s=%0b %s=%0b %s=%0d",
                   "success", s, "full_reject", fr, "occupancy", occ);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (s !== want.success) begin
            $error("success: expected %0b, got %0b", want.success, s);
            errors++;
         end
         if (fr !== want.full_reject) begin
            $error("full_reject: expected %0b, got %0b", want.full_reject, fr);
            errors++;
         end
         if (occ !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occ);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   sse_req_if req_bus ();
   sse_rsp_if rsp_bus ();

   sorted_set_engine_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   key_set_tracker book = new();

   // Percent chance per cycle that the sender idles / the receiver stalls.
   int req_idle_pct = 13;
   int rsp_stall_pct = 13;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Pick a key: a held one with the given chance, otherwise any 16-bit value.
   function automatic logic [REQ_KEY_BITS-1:0] pick_key(int held_pct);
      logic [REQ_KEY_BITS-1:0] k;
      if (book.size() > 0 && $urandom_range(99) < held_pct) begin
         k = book.key_at($urandom_range(book.size() - 1));
      end else begin
         k = REQ_KEY_BITS'($urandom);
      end
      return k;
   endfunction

   // Offer one request from a falling edge, hold it until taken, log it in the
   // mirror at the accepting edge, and return at the next falling edge.
   task automatic send_request(input logic [OPCODE_BITS-1:0] op,
                               input logic [REQ_KEY_BITS-1:0] k);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= op;
      req_bus.key <= k;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      book.apply_request(op, k);
      @(negedge clock);
   endtask

   // Receiver: random stalls, plus one long hold-off once traffic is flowing so the
   // output register and the pending commit fill and the request side backs up.
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && book.responses_checked >= HOLD_OFF_AFTER) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Check responses at the rising edge and count cycles with no handshake at all.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         book.check_response(rsp_bus.success, rsp_bus.full_reject, rsp_bus.occupancy);
      end
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
   end

   // Watchdog: a stuck handshake ends the run.
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int roll;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_MEMBER;
      req_bus.key = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty store, head and tail keys, duplicates, the unused opcode,
      // and removal of the largest key, which must leave the rest in place.
      send_request(OP_MEMBER, 16'h0000);
      send_request(OP_DELETE, 16'h0000);
      send_request(OP_INSERT, 16'h8000);
      send_request(OP_INSERT, 16'h0000);
      send_request(OP_INSERT, 16'hFFFF);
      send_request(OP_INSERT, 16'h8000);
      send_request(OP_MEMBER, 16'hFFFF);
      send_request(OP_MEMBER, 16'h7FFF);
      send_request(OP_UNUSED, 16'hFFFF);
      send_request(OP_UNUSED, 16'h0000);
      send_request(OP_INSERT, 16'h5555);
      send_request(OP_INSERT, 16'hAAAA);
      send_request(OP_DELETE, 16'hFFFF);
      send_request(OP_MEMBER, 16'hAAAA);
      send_request(OP_MEMBER, 16'h0000);
      send_request(OP_DELETE, 16'h0000);
      send_request(OP_DELETE, 16'h1234);
      send_request(OP_DELETE, 16'h5555);
      send_request(OP_MEMBER, 16'h8000);
      send_request(OP_INSERT, 16'hFFFF);
      send_request(OP_DELETE, 16'h8000);
      send_request(OP_DELETE, 16'hAAAA);
      send_request(OP_DELETE, 16'hFFFF);
      send_request(OP_DELETE, 16'hFFFF);
      send_request(OP_MEMBER, 16'h8000);

      // Mixed traffic at full rate on both sides: back-to-back requests, no stalls.
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (200) begin
         roll = $urandom_range(99);
         if (roll < 35) begin
            send_request(OP_INSERT, pick_key(30));
         end else if (roll < 60) begin
            send_request(OP_MEMBER, pick_key(50));
         end else if (roll < 93) begin
            send_request(OP_DELETE, pick_key(60));
         end else begin
            send_request(OP_UNUSED, pick_key(50));
         end
      end
      req_idle_pct = 13;
      rsp_stall_pct = 13;

      // Fill: mostly fresh inserts until the store holds its full capacity.
      while (book.size() < STORE_DEPTH) begin
         roll = $urandom_range(99);
         if (roll < 88) begin
            send_request(OP_INSERT, pick_key(0));
         end else if (roll < 94) begin
            send_request(OP_MEMBER, pick_key(50));
         end else begin
            send_request(OP_DELETE, pick_key(70));
         end
      end

      // At capacity: rejected new keys, duplicate inserts, and delete/refill churn.
      repeat (100) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            send_request(OP_INSERT, pick_key(0));
         end else if (roll < 60) begin
            send_request(OP_INSERT, pick_key(100));
         end else if (roll < 75) begin
            send_request(OP_MEMBER, pick_key(50));
         end else if (roll < 90) begin
            send_request(OP_DELETE, pick_key(100));
         end else begin
            send_request(OP_UNUSED, pick_key(50));
         end
      end

      // Drain: delete-heavy to shift the chain down from the top.
      repeat (150) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            send_request(OP_DELETE, pick_key(100));
         end else if (roll < 85) begin
            send_request(OP_DELETE, pick_key(0));
         end else if (roll < 95) begin
            send_request(OP_MEMBER, pick_key(50));
         end else begin
            send_request(OP_INSERT, pick_key(20));
         end
      end
      req_bus.valid <= 1'b0;

      // Wait for every owed response, then let any stray one show up.
      while (book.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (book.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
